// File: rtl/idps_pkg.sv
// ----------------------------------------------------------------------------
// idps_pkg
// Shared constants, types and helpers for the difference, posterize and
// sharpen stream filter.
// ----------------------------------------------------------------------------
package idps_pkg;

   localparam int IMG_WIDTH    = 256;
   localparam int IMG_HEIGHT   = 256;
   localparam int FRAME_PIXELS = IMG_WIDTH * IMG_HEIGHT;
   localparam int FRAME_ITEMS  = FRAME_PIXELS + IMG_WIDTH + 1;

   localparam int COL_W   = $clog2(IMG_WIDTH);
   localparam int ROW_W   = $clog2(IMG_HEIGHT);
   localparam int COUNT_W = $clog2(FRAME_ITEMS);

   localparam logic [7:0] LOW_THR_RESET  = 8'd32;
   localparam logic [7:0] HIGH_THR_RESET = 8'd96;

   typedef enum logic [1:0] {
      CODE_ZERO = 2'd0,
      CODE_MID  = 2'd1,
      CODE_FULL = 2'd2
   } level_code_type;

   typedef enum logic {
      CSR_LOW_THR  = 1'b0,
      CSR_HIGH_THR = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [1:0]       code;
      logic [COL_W-1:0] col;
      logic             has_out;
      logic             border;
      logic             last;
   } stage_item_type;

   function automatic logic [7:0] code_value(input logic [1:0] code);
      logic [7:0] val;
      case (code)
         CODE_ZERO: val = 8'd0;
         CODE_MID:  val = 8'd128;
         default:   val = 8'd255;
      endcase
      return val;
   endfunction

endpackage

// File: rtl/image_diff_posterize_sharpen.sv
// ----------------------------------------------------------------------------
// image_diff_posterize_sharpen
// Posterizes the absolute difference of two raster images and applies a
// 3x3 Laplacian sharpen with clamping, one pixel pair per transaction.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake              Payload
//  req_     in         req_tvalid/req_tready  tdata pixel_a, pixel_b; tuser flush
//  rsp_     out        rsp_tvalid/rsp_tready  tdata out_pixel; tlast frame_last
//  csr_     in         csr_valid/csr_ready    csr_index, csr_data
//
// One transaction is taken per cycle while the input stage is free or moving on; its
// result, if any, is registered through the input stage and then the result register.
// The line stores are arrays read at accept and written when the item leaves
// the input stage, and are not cleared at reset. Reset clears the counters and
// the window and loads the thresholds with their reset values. A stalled result
// holds the input stage only when the item in it also produces a result.
module image_diff_posterize_sharpen
   import idps_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] pixel_a, [15:8] pixel_b
   input  logic        req_tuser,   // [0] flush
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_pixel
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [7:0]  csr_data
);

   logic [7:0]         low_thr_ff, high_thr_ff;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [COL_W-1:0]   out_col_ff, out_col_in;
   logic [ROW_W-1:0]   out_row_ff, out_row_in;

   logic               a_vld_ff, a_vld_in;
   stage_item_type     a_ff, a_in;
   logic [1:0]         a_old_ff, a_new_ff;

   logic [1:0]         win_col_ff [3];
   logic [1:0]         win_mid_ff;

   logic               o_vld_ff, o_vld_in;
   logic [7:0]         o_pixel_ff, o_pixel_in;
   logic               o_last_ff;

   logic [1:0]         older_mem [IMG_WIDTH];
   logic [1:0]         newer_mem [IMG_WIDTH];

   logic               req_go, a_go, out_free;
   logic [7:0]         pix_a, pix_b, diff;
   logic [11:0]        pos_sum, neg_sum, net;

   assign pix_a = req_tdata[7:0];
   assign pix_b = req_tdata[15:8];

   assign out_free   = !o_vld_ff || rsp_tready;
   assign a_go       = a_vld_ff && (!a_ff.has_out || out_free);
   assign req_tready = !a_vld_ff || a_go;
   assign req_go     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         low_thr_ff  <= LOW_THR_RESET;
         high_thr_ff <= HIGH_THR_RESET;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_LOW_THR:  low_thr_ff  <= csr_data;
            CSR_HIGH_THR: high_thr_ff <= csr_data;
         endcase
      end
   end

   always_comb begin
      diff = (pix_a >= pix_b) ? (pix_a - pix_b) : (pix_b - pix_a);
      a_in.code = CODE_ZERO;
      if (!req_tuser && (count_ff < COUNT_W'(FRAME_PIXELS))) begin
         if (diff < low_thr_ff) begin
            a_in.code = CODE_ZERO;
         end else if (diff < high_thr_ff) begin
            a_in.code = CODE_MID;
         end else begin
            a_in.code = CODE_FULL;
         end
      end
      a_in.col     = col_ff;
      a_in.has_out = count_ff >= COUNT_W'(IMG_WIDTH + 1);
      a_in.border  = (out_row_ff == '0) || (out_row_ff == ROW_W'(IMG_HEIGHT - 1)) ||
                     (out_col_ff == '0) || (out_col_ff == COL_W'(IMG_WIDTH - 1));
      a_in.last    = a_in.has_out && (out_row_ff == ROW_W'(IMG_HEIGHT - 1)) &&
                     (out_col_ff == COL_W'(IMG_WIDTH - 1));

      count_in   = count_ff;
      col_in     = col_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (req_go) begin
         if (a_in.last) begin
            count_in   = '0;
            col_in     = '0;
            out_col_in = '0;
            out_row_in = '0;
         end else begin
            count_in = count_ff + 1'b1;
            col_in   = (col_ff == COL_W'(IMG_WIDTH - 1)) ? '0 : col_ff + 1'b1;
            if (a_in.has_out) begin
               if (out_col_ff == COL_W'(IMG_WIDTH - 1)) begin
                  out_col_in = '0;
                  out_row_in = out_row_ff + 1'b1;
               end else begin
                  out_col_in = out_col_ff + 1'b1;
               end
            end
         end
      end
   end

   always_comb begin
      a_vld_in = req_go ? 1'b1 : (a_go ? 1'b0 : a_vld_ff);
      o_vld_in = (a_go && a_ff.has_out) ? 1'b1 : (rsp_tready ? 1'b0 : o_vld_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         col_ff     <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         a_vld_ff   <= 1'b0;
         o_vld_ff   <= 1'b0;
      end else begin
         count_ff   <= count_in;
         col_ff     <= col_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         a_vld_ff   <= a_vld_in;
         o_vld_ff   <= o_vld_in;
      end
   end

   // Line store read at accept, with a bypass for the write of the same column.
   always_ff @(posedge clock) begin
      if (req_go) begin
         a_ff <= a_in;
         if (a_go && (a_ff.col == col_ff)) begin
            a_old_ff <= a_new_ff;
            a_new_ff <= a_ff.code;
         end else begin
            a_old_ff <= older_mem[col_ff];
            a_new_ff <= newer_mem[col_ff];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (a_go) begin
         older_mem[a_ff.col] <= a_new_ff;
         newer_mem[a_ff.col] <= a_ff.code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_col_ff[0] <= CODE_ZERO;
         win_col_ff[1] <= CODE_ZERO;
         win_col_ff[2] <= CODE_ZERO;
         win_mid_ff    <= CODE_ZERO;
      end else if (a_go) begin
         if (a_ff.has_out && a_ff.last) begin
            win_col_ff[0] <= CODE_ZERO;
            win_col_ff[1] <= CODE_ZERO;
            win_col_ff[2] <= CODE_ZERO;
            win_mid_ff    <= CODE_ZERO;
         end else begin
            win_col_ff[0] <= a_old_ff;
            win_col_ff[1] <= a_new_ff;
            win_col_ff[2] <= a_ff.code;
            win_mid_ff    <= win_col_ff[1];
         end
      end
   end

   always_comb begin
      pos_sum = {2'b00, code_value(win_col_ff[1]), 2'b00} +
                {4'b0000, code_value(win_col_ff[1])};
      neg_sum = {4'b0000, code_value(win_col_ff[0])} +
                {4'b0000, code_value(win_col_ff[2])} +
                {4'b0000, code_value(win_mid_ff)} +
                {4'b0000, code_value(a_new_ff)};
      net = pos_sum - neg_sum;
      if (a_ff.border || (pos_sum <= neg_sum)) begin
         o_pixel_in = 8'd0;
      end else if (net > 12'd255) begin
         o_pixel_in = 8'd255;
      end else begin
         o_pixel_in = net[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (a_go && a_ff.has_out) begin
         o_pixel_ff <= o_pixel_in;
         o_last_ff  <= a_ff.last;
      end
   end

   assign rsp_tvalid = o_vld_ff;
   assign rsp_tdata  = o_pixel_ff;
   assign rsp_tlast  = o_last_ff;

`ifndef SYNTHESIS
   a_last_is_border: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata == 8'd0)
      else $error("final pixel of a frame is not zero");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff < COUNT_W'(FRAME_ITEMS) && col_ff <= COL_W'(IMG_WIDTH - 1))
      else $error("item counter out of range");

   a_out_row_range: assert property (@(posedge clock) disable iff (reset)
      out_row_ff <= ROW_W'(IMG_HEIGHT - 1))
      else $error("result row counter out of range");

   a_result_on_consume: assert property (@(posedge clock) disable iff (reset)
      a_go && a_ff.has_out |=> rsp_tvalid)
      else $error("result lost after input stage was consumed");
`endif

endmodule
